### hw/rtl/dpsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dpsc_pkg;

  // Fixed point and lane count
  localparam int unsigned GAIN_FRAC_BITS = 8;
  localparam int unsigned LANES          = 2;  // lanes carried by one item
  localparam int unsigned CHANNELS       = 2;  // lanes actually computed

  // Register reset values
  localparam logic [15:0] KP_RESET   = 16'd21760;  // 85.0
  localparam logic [15:0] KI_RESET   = 16'd435;    // about 1.7
  localparam logic [15:0] KD_RESET   = 16'd0;
  localparam logic [14:0] ILIM_RESET = 15'd500;
  localparam logic [14:0] DLIM_RESET = 15'd999;

  // Register indexes
  typedef enum logic [2:0] {
    CFG_GAIN_P = 3'd0,
    CFG_GAIN_I = 3'd1,
    CFG_GAIN_D = 3'd2,
    CFG_ILIM   = 3'd3,
    CFG_DLIM   = 3'd4
  } cfg_idx_e;

  // Shared settings seen by every lane
  typedef struct packed {
    logic [15:0] kp;
    logic [15:0] ki;
    logic [15:0] kd;
    logic [14:0] ilim;
    logic [14:0] dlim;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] target_left;
    logic signed [15:0] speed_left;
    logic signed [15:0] target_right;
    logic signed [15:0] speed_right;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] drive_left;
    logic signed [15:0] drive_right;
  } out_item_t;

endpackage

`default_nettype wire

### hw/rtl/dpsc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dpsc_in_if;
  logic               valid;
  logic               ready;
  dpsc_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hw/rtl/dpsc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dpsc_out_if;
  logic                valid;
  logic                ready;
  dpsc_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hw/rtl/dpsc_lane.sv
`timescale 1ns / 1ps
`default_nettype none

// One PID lane: error/integral stage, multiply stage, sum stage, scale/clamp stage
module dpsc_lane (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,      // pipeline advance
  input  wire logic               take_i,    // item transfer this cycle
  input  wire logic signed [15:0] target_i,
  input  wire logic signed [15:0] speed_i,
  input  wire dpsc_pkg::cfg_t     cfg_i,
  output logic signed [15:0]      drive_o
);
  import dpsc_pkg::*;

  // Lane state
  logic signed [15:0] accum_q, accum_d;
  logic signed [16:0] last_q;

  // Stage registers
  logic signed [16:0] err_q;
  logic signed [15:0] acc_q;
  logic signed [17:0] derr_q;
  logic signed [33:0] prod_p_q, prod_p_d;
  logic signed [32:0] prod_i_q, prod_i_d;
  logic signed [34:0] prod_d_q, prod_d_d;
  logic signed [35:0] sum_q, sum_d;
  logic signed [15:0] drive_q, drive_d;

  logic signed [16:0] err_d;
  logic signed [17:0] acc_raw;
  logic signed [17:0] ilim_s;
  logic signed [17:0] derr_d;
  logic signed [16:0] kp_s, ki_s, kd_s;
  logic        [35:0] mag;
  logic        [35:0] mag_sh;
  logic        [14:0] mag_c;

  // Error, clamped integral and error difference
  always_comb begin
    err_d   = {target_i[15], target_i} - {speed_i[15], speed_i};
    acc_raw = {{2{accum_q[15]}}, accum_q} + {err_d[16], err_d};
    ilim_s  = {3'b000, cfg_i.ilim};
    if (acc_raw > ilim_s) begin
      accum_d = ilim_s[15:0];
    end else if (acc_raw < -ilim_s) begin
      accum_d = 16'(-ilim_s);
    end else begin
      accum_d = acc_raw[15:0];
    end
    derr_d = {err_d[16], err_d} - {last_q[16], last_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
      last_q  <= '0;
    end else if (take_i) begin
      accum_q <= accum_d;
      last_q  <= err_d;
    end
  end

  // Three independent products, gains taken as positive signed
  always_comb begin
    kp_s     = {1'b0, cfg_i.kp};
    ki_s     = {1'b0, cfg_i.ki};
    kd_s     = {1'b0, cfg_i.kd};
    prod_p_d = kp_s * err_q;
    prod_i_d = ki_s * acc_q;
    prod_d_d = kd_s * derr_q;
    sum_d    = {{2{prod_p_q[33]}}, prod_p_q} + {{3{prod_i_q[32]}}, prod_i_q}
             + {prod_d_q[34], prod_d_q};
  end

  // Magnitude scaling truncates toward zero, then the drive clamp
  always_comb begin
    mag    = sum_q[35] ? 36'(-sum_q) : 36'(sum_q);
    mag_sh = mag >> GAIN_FRAC_BITS;
    if (mag_sh > {21'd0, cfg_i.dlim}) begin
      mag_c = cfg_i.dlim;
    end else begin
      mag_c = mag_sh[14:0];
    end
    drive_d = sum_q[35] ? (16'sd0 - $signed({1'b0, mag_c})) : $signed({1'b0, mag_c});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      err_q    <= err_d;
      acc_q    <= accum_d;
      derr_q   <= derr_d;
      prod_p_q <= prod_p_d;
      prod_i_q <= prod_i_d;
      prod_d_q <= prod_d_d;
      sum_q    <= sum_d;
      drive_q  <= drive_d;
    end
  end

  assign drive_o = drive_q;

endmodule

`default_nettype wire

### hw/rtl/dpsc_merge.sv
`timescale 1ns / 1ps
`default_nettype none

// Packs the lane drives into one result and holds it in a two-entry skid queue
module dpsc_merge (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic signed [15:0] drive_i [dpsc_pkg::LANES],
  output logic                    ready_o,
  dpsc_out_if.source              out_o
);
  import dpsc_pkg::*;

  out_item_t   mem_q [2];
  out_item_t   item;
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        pop;

  // Lane merge
  always_comb begin
    item.drive_left  = drive_i[0];
    item.drive_right = drive_i[1];
  end

  assign ready_o       = (cnt_q != 2'd2);
  assign out_o.valid   = (cnt_q != 2'd0);
  assign out_o.payload = mem_q[rp_q];
  assign pop           = out_o.valid && out_o.ready;

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= item;
    end
  end

  // Queue pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

### hw/rtl/dual_pid_speed_controller_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Dual-lane positional PID speed controller. Each transfer on in_i is one control
// tick carrying target and measured speed for the left and right motors; each
// tick yields exactly one transfer on out_o with the two clamped drive values.
// Both lanes share the gains and limits written through cfg_we_i/cfg_idx_i/
// cfg_data_i (0 P gain, 1 I gain, 2 D gain, gains unsigned Q8.8; 3 integral
// limit, 4 drive limit; other indexes are ignored). One tick is taken every
// clock cycle while in_i.ready is high: the integral and previous error update
// in the cycle of the transfer, and the four-stage lane pipeline (error,
// multiply, sum, scale and clamp) feeds a two-entry output queue that holds
// results for out_o. in_i.ready drops only while that queue is full.
module dual_pid_speed_controller_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  dpsc_in_if.sink          in_i,
  dpsc_out_if.source       out_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  import dpsc_pkg::*;

  localparam int unsigned STAGES = 4;

  cfg_t               cfg_q;
  logic [STAGES-1:0]  vld_q;
  logic               en;
  logic               take;
  logic signed [15:0] target [LANES];
  logic signed [15:0] speed  [LANES];
  logic signed [15:0] drive  [LANES];

  // Settings registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp   <= KP_RESET;
      cfg_q.ki   <= KI_RESET;
      cfg_q.kd   <= KD_RESET;
      cfg_q.ilim <= ILIM_RESET;
      cfg_q.dlim <= DLIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN_P: cfg_q.kp   <= cfg_data_i;
        CFG_GAIN_I: cfg_q.ki   <= cfg_data_i;
        CFG_GAIN_D: cfg_q.kd   <= cfg_data_i;
        CFG_ILIM:   cfg_q.ilim <= cfg_data_i[14:0];
        CFG_DLIM:   cfg_q.dlim <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Pipeline advances whenever the output queue has room
  assign in_i.ready = en;
  assign take       = in_i.valid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[STAGES-2:0], take};
    end
  end

  // Lane fan-out
  assign target[0] = in_i.payload.target_left;
  assign speed[0]  = in_i.payload.speed_left;
  assign target[1] = in_i.payload.target_right;
  assign speed[1]  = in_i.payload.speed_right;

  for (genvar c = 0; c < LANES; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      dpsc_lane u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .en_i     (en),
        .take_i   (take),
        .target_i (target[c]),
        .speed_i  (speed[c]),
        .cfg_i    (cfg_q),
        .drive_o  (drive[c])
      );
    end else begin : g_off
      assign drive[c] = 16'sd0;
    end
  end

  dpsc_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (en && vld_q[STAGES-1]),
    .drive_i (drive),
    .ready_o (en),
    .out_o   (out_o)
  );

  // A transfer enters the first stage
  a_take_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> vld_q[0]) else $error("transferred tick missing from first stage");

  // Stall only while a result is held at the output
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid) else $error("input stalled with no result pending");

  // Delivered drives respect the drive limit
  a_drive_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |->
      ($signed(out_o.payload.drive_left) <= $signed({1'b0, cfg_q.dlim})) &&
      ($signed(out_o.payload.drive_left) >= -$signed({1'b0, cfg_q.dlim})) &&
      ($signed(out_o.payload.drive_right) <= $signed({1'b0, cfg_q.dlim})) &&
      ($signed(out_o.payload.drive_right) >= -$signed({1'b0, cfg_q.dlim})))
    else $error("drive outside limit");

endmodule

`default_nettype wire

### verif/dual_pid_speed_controller_unit_tb.sv
`timescale 1ns / 1ps

module dual_pid_speed_controller_unit_tb;
  import dpsc_pkg::*;

  localparam int unsigned CFG_REG_COUNT = 5;
  localparam int unsigned CFG_IDX_TOP   = (1 << $bits(cfg_idx_e)) - 1;
  localparam int unsigned GAP_MAX       = 13;
  localparam int unsigned SETTLE_CYCLES = 16;   // well past the pipeline latency
  localparam int unsigned DRAIN_LIMIT   = 4000;
  localparam int unsigned HOLD_CYCLES   = 90;
  localparam int unsigned PHASE_TICKS   = 160;
  localparam int unsigned PHASES        = 8;
  localparam longint      TIMEOUT_NS    = 4_000_000;

  // Drive predictor and store of expected drive pairs
  class drive_scoreboard;
    int kp, ki, kd, ilim, dlim;
    int integ[LANES];
    int prev_err[LANES];
    out_item_t expected_drives[$];
    int unsigned errors, ticks, drives;

    function new();
      kp   = KP_RESET;
      ki   = KI_RESET;
      kd   = KD_RESET;
      ilim = ILIM_RESET;
      dlim = DLIM_RESET;
      foreach (integ[l]) begin
        integ[l]    = 0;
        prev_err[l] = 0;
      end
      errors = 0;
      ticks  = 0;
      drives = 0;
    endfunction

    // Register write as the block sees it; limits keep 15 bits
    function void apply_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        CFG_GAIN_P: kp = data;
        CFG_GAIN_I: ki = data;
        CFG_GAIN_D: kd = data;
        CFG_ILIM:   ilim = data[14:0];
        CFG_DLIM:   dlim = data[14:0];
        default: ;
      endcase
    endfunction

    // One lane of positional PID with clamped integral and clamped drive
    function logic signed [15:0] lane_drive(int lane, int target, int speed);
      int err;
      int acc;
      longint sum;
      longint mag;
      err = target - speed;
      acc = integ[lane] + err;
      if (acc > ilim) acc = ilim;
      else if (acc < -ilim) acc = -ilim;
      sum = longint'(kp) * err + longint'(ki) * acc
          + longint'(kd) * (err - prev_err[lane]);
      integ[lane]    = acc;
      prev_err[lane] = err;
      // scale the magnitude so that rounding is toward zero
      mag = (sum < 0) ? -sum : sum;
      mag = mag >> GAIN_FRAC_BITS;
      if (mag > dlim) mag = dlim;
      return 16'((sum < 0) ? -mag : mag);
    endfunction

    function void note_tick(in_item_t tick);
      out_item_t want;
      ticks++;
      want.drive_left  = lane_drive(0, tick.target_left, tick.speed_left);
      want.drive_right = '0;
      // an uncomputed right lane holds its state and drives zero
      if (CHANNELS >= 2)
        want.drive_right = lane_drive(1, tick.target_right, tick.speed_right);
      expected_drives.push_back(want);
    endfunction

    function void check_drive(out_item_t got);
      out_item_t want;
      drives++;
      if (expected_drives.size() == 0) begin
        errors++;
        $display("%0t: drive transfer with none expected: left %0d, right %0d",
                 $time, got.drive_left, got.drive_right);
        return;
      end
      want = expected_drives.pop_front();
      if (got.drive_left !== want.drive_left) begin
        errors++;
        $display("%0t: drive_left mismatch: expected %0d, actual %0d",
                 $time, want.drive_left, got.drive_left);
      end
      if (got.drive_right !== want.drive_right) begin
        errors++;
        $display("%0t: drive_right mismatch: expected %0d, actual %0d",
                 $time, want.drive_right, got.drive_right);
      end
    endfunction

    function int unsigned pending();
      return expected_drives.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  dpsc_in_if  in_if ();
  dpsc_out_if out_if ();

  drive_scoreboard sb;
  bit              sender_idles;
  bit              receiver_idles;
  int unsigned     sink_hold_req;
  int unsigned     settings_applied;

  dual_pid_speed_controller_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

  // Drive sink: random stalls, plus a long hold-off on request
  initial begin : drive_sink
    int unsigned stall;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = 0;
      if (sink_hold_req != 0) begin
        stall         = sink_hold_req;
        sink_hold_req = 0;
      end else if (receiver_idles) begin
        stall = $urandom_range(0, GAP_MAX);
      end
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
      sb.check_drive(out_if.payload);
      @(negedge clk_i);
    end
  end

  // One tick transfer; called and left at a falling edge
  task automatic send_tick(input in_item_t tick);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(0, GAP_MAX) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.payload <= tick;
    in_if.valid   <= 1'b1;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.note_tick(tick);
    @(negedge clk_i);
  endtask

  task automatic send_speeds(input logic signed [15:0] tl, input logic signed [15:0] sl,
                             input logic signed [15:0] tr, input logic signed [15:0] sr);
    in_item_t tick;
    tick.target_left  = tl;
    tick.speed_left   = sl;
    tick.target_right = tr;
    tick.speed_right  = sr;
    send_tick(tick);
  endtask

  // Stop offering ticks and wait for every outstanding drive pair
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    in_if.valid <= 1'b0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (sb.pending() != 0) begin
      sb.errors += sb.pending();
      $display("%0t: %0d drive results never arrived", $time, sb.pending());
      sb.expected_drives.delete();
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.apply_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] kp, input logic [15:0] ki,
                            input logic [15:0] kd, input logic [15:0] ilim,
                            input logic [15:0] dlim);
    write_reg(CFG_GAIN_P, kp);
    write_reg(CFG_GAIN_I, ki);
    write_reg(CFG_GAIN_D, kd);
    write_reg(CFG_ILIM, ilim);
    write_reg(CFG_DLIM, dlim);
    settings_applied++;
  endtask

  // Writes to indexes past the last register must change nothing
  task automatic write_unused_regs(input bit all_ones);
    for (int idx = CFG_REG_COUNT; idx <= CFG_IDX_TOP; idx++)
      write_reg(3'(idx), all_ones ? 16'hFFFF : 16'($urandom));
  endtask

  // Target and speed for one lane: mostly near each other, some wide, some corners
  function automatic void pick_lane(output logic signed [15:0] target,
                                    output logic signed [15:0] speed);
    int corners[5] = '{-32768, -1, 0, 1, 32767};
    int s;
    int t;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        s = $signed(16'($urandom));
        t = s + int'($urandom_range(0, 128)) - 64;
      end
      5, 6: begin
        s = $signed(16'($urandom));
        t = $signed(16'($urandom));
      end
      7: begin
        s = corners[$urandom_range(0, 4)];
        t = corners[$urandom_range(0, 4)];
      end
      default: begin
        s = $signed(16'($urandom));
        t = s + int'($urandom_range(0, 4000)) - 2000;
      end
    endcase
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    target = 16'(t);
    speed  = 16'(s);
  endfunction

  // Main sequence
  initial begin : run_test
    in_item_t tick;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    in_if.valid      = 1'b0;
    in_if.payload    = '0;
    sender_idles     = 1'b0;
    receiver_idles   = 1'b0;
    sink_hold_req    = 0;
    settings_applied = 1;
    sb = new();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset gains: full-scale errors, integral clamp, zero error
    send_speeds(0, 0, 0, 0);
    send_speeds(32767, -32768, -32768, 32767);
    send_speeds(32767, -32768, -32768, 32767);
    send_speeds(-32768, 32767, 32767, -32768);
    send_speeds(32767, 32767, -32768, -32768);
    send_speeds(1, 0, 0, 1);
    send_speeds(-1, 0, 0, -1);
    send_speeds(-32768, -32768, 32767, 32767);
    send_speeds(100, 95, -100, -95);
    drain_results();

    // Every register at full scale; the limits drop their top data bit
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_speeds(32767, -32768, -32768, 32767);
    send_speeds(32767, -32768, -32768, 32767);
    send_speeds(-32768, 32767, 32767, -32768);
    send_speeds(0, 0, 0, 0);
    drain_results();

    // Zero limits: integral pinned at zero, drive forced to zero
    set_config(16'h0100, 16'hFFFF, 16'h0080, 16'h0000, 16'h0000);
    send_speeds(1000, 0, -1000, 0);
    send_speeds(32767, -32768, -32768, 32767);
    drain_results();

    // Tiny proportional gain: scaled sum truncates toward zero
    set_config(16'h0001, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF);
    send_speeds(0, 1, 1, 0);
    send_speeds(0, 300, 300, 0);
    send_speeds(-32768, 32767, 32767, -32768);
    drain_results();
    write_unused_regs(1'b1);
    send_speeds(0, 300, 300, 0);
    drain_results();

    // Random phases, one register setting each
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: set_config(KP_RESET, KI_RESET, KD_RESET, ILIM_RESET, DLIM_RESET);
        1: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF);
        2: set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'h0000,
                      16'($urandom));
        3: set_config(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                      16'($urandom_range(0, 3)), 16'($urandom), 16'h7FFF);
        4: set_config(16'h0000, 16'h0000, 16'($urandom), 16'($urandom), 16'($urandom));
        5: set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'h0000);
        default: set_config(16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom));
      endcase
      if (phase % 3 == 2) write_unused_regs(1'b0);

      for (int unsigned i = 0; i < PHASE_TICKS; i++) begin
        if (i % 40 == 0) begin
          sender_idles   = ($urandom_range(0, 2) != 0);
          receiver_idles = ($urandom_range(0, 2) != 0);
        end
        // long output hold-off while ticks keep coming back to back
        if (i == 50 && phase % 2 == 0) begin
          sink_hold_req = HOLD_CYCLES;
          sender_idles  = 1'b0;
        end
        // sender pauses until every drive pair is back
        if (i == 110 && phase % 2 == 1) drain_results();
        pick_lane(tick.target_left, tick.speed_left);
        pick_lane(tick.target_right, tick.speed_right);
        send_tick(tick);
      end
      drain_results();
    end

    $display("Run covered %0d ticks and %0d drive results over %0d register settings,",
             sb.ticks, sb.drives, settings_applied);
    $display("with full-scale and zero limits, ignored indexes, stalls and long hold-offs.");
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
